### rtl/core/lsqs_pkg.sv
package lsqs_pkg;

  // fixed field widths
  localparam int VAL_W = 32;
  localparam int IMM_W = 16;
  localparam int PC_W  = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SQUASH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HOLD   = 5'b00010,
    S_POP    = 5'b00100,
    S_SQ_RD  = 5'b01000,
    S_SQ_CMP = 5'b10000
  } lsqs_state_t;

  // result word control, ctrl -> output stage
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    pop;   // take entry fields from memory read data
    logic    full;
  } res_ctl_t;

endpackage

### rtl/core/load_store_queue_with_squash_unit.sv
// Order: insert, refused insert, pop/squash on empty and the unused code load their word into
//   the output register at accept (parked in S_HOLD while it is busy); pop first passes the
//   entry memory read register; squash reads the tail tag at accept, then compares per entry.
// Throughput: one insert word per cycle while the output is free; one op in flight otherwise.
// Reset (rst_n low, synchronous): count, head/tail pointers, sequencer and output valid clear;
//   entry and tag memories are not cleared, only entries below the count are ever read.
module load_store_queue_with_squash_unit
  import lsqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int PHYS_REGS   = 64,
  parameter int TAG_COUNT   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_req_type,
  input  logic                                  in_is_store,
  input  logic [$clog2(PHYS_REGS)-1:0]          in_dest_phys,
  input  logic [$clog2(PHYS_REGS)-1:0]          in_src1_phys,
  input  logic signed [VAL_W-1:0]               in_src1_value,
  input  logic                                  in_src1_ready,
  input  logic [$clog2(PHYS_REGS)-1:0]          in_src2_phys,
  input  logic signed [IMM_W-1:0]               in_imm,
  input  logic [PC_W-1:0]                       in_pc_in,
  input  logic [$clog2(TAG_COUNT)-1:0]          in_cf_tag,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_status,
  output logic [$clog2(QUEUE_DEPTH)-1:0]        out_slot_index,
  output logic                                  out_is_store,
  output logic [$clog2(PHYS_REGS)-1:0]          out_dest,
  output logic [$clog2(PHYS_REGS)-1:0]          out_src1,
  output logic signed [VAL_W-1:0]               out_src1_value,
  output logic [$clog2(PHYS_REGS)-1:0]          out_src2,
  output logic signed [IMM_W-1:0]               out_imm,
  output logic [PC_W-1:0]                       out_pc,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_occupancy,
  output logic                                  out_is_full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_removed
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(PHYS_REGS);
  localparam int TW = $clog2(TAG_COUNT);

  // entry word layout, LSB first: pc, imm, src1 value, is_store, dest, src1, src2, src1_ready
  localparam int IMM_LSB  = PC_W;
  localparam int VAL_LSB  = IMM_LSB + IMM_W;
  localparam int ST_LSB   = VAL_LSB + VAL_W;
  localparam int DEST_LSB = ST_LSB + 1;
  localparam int SRC1_LSB = DEST_LSB + RW;
  localparam int SRC2_LSB = SRC1_LSB + RW;
  localparam int EW       = SRC2_LSB + RW + 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] wr_entry;
  logic [EW-1:0] rd_entry;
  logic [TW-1:0] rd_tag;

  res_ctl_t      res_ctl;
  logic [AW-1:0] res_slot;
  logic [CW-1:0] res_occupancy;
  logic [CW-1:0] res_removed;
  logic          res_ready;
  logic          res_take;

  logic          out_valid_r;
  logic [1:0]    status_r;
  logic [AW-1:0] slot_r;
  logic          is_store_r;
  logic [RW-1:0] dest_r;
  logic [RW-1:0] src1_r;
  logic [VAL_W-1:0] src1_value_r;
  logic [RW-1:0] src2_r;
  logic [IMM_W-1:0] imm_r;
  logic [PC_W-1:0] pc_r;
  logic [CW-1:0] occupancy_r;
  logic          is_full_r;
  logic [CW-1:0] removed_r;

  assign wr_entry = {in_src1_ready, in_src2_phys, in_src1_phys, in_dest_phys, in_is_store,
                     in_src1_value, in_imm, in_pc_in};

  // entry storage: payload word + control-flow tag, one write and one read port
  lsqs_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .EW          (EW),
    .TW          (TW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .wr_tag   (in_cf_tag),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_tag   (rd_tag)
  );

  // pointer/count bookkeeping and the pop/squash sequencer
  // one op at a time, so a write never overlaps a read of the same entry
  lsqs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TW          (TW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_cf_tag     (in_cf_tag),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .rd_tag        (rd_tag),
    .res_ready     (res_ready),
    .res_ctl       (res_ctl),
    .res_slot      (res_slot),
    .res_occupancy (res_occupancy),
    .res_removed   (res_removed)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;
  assign res_take  = res_ctl.valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // popped fields come straight from the read register; zero for anything else
  always_ff @(posedge clk) begin
    if (res_take) begin
      status_r     <= res_ctl.status;
      slot_r       <= res_slot;
      occupancy_r  <= res_occupancy;
      is_full_r    <= res_ctl.full;
      removed_r    <= res_removed;
      if (res_ctl.pop) begin
        is_store_r   <= rd_entry[ST_LSB];
        dest_r       <= rd_entry[DEST_LSB +: RW];
        src1_r       <= rd_entry[SRC1_LSB +: RW];
        src1_value_r <= rd_entry[VAL_LSB +: VAL_W];
        src2_r       <= rd_entry[SRC2_LSB +: RW];
        imm_r        <= rd_entry[IMM_LSB +: IMM_W];
        pc_r         <= rd_entry[0 +: PC_W];
      end else begin
        is_store_r   <= 1'b0;
        dest_r       <= '0;
        src1_r       <= '0;
        src1_value_r <= '0;
        src2_r       <= '0;
        imm_r        <= '0;
        pc_r         <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot_index = slot_r;
  assign out_is_store   = is_store_r;
  assign out_dest       = dest_r;
  assign out_src1       = src1_r;
  assign out_src1_value = $signed(src1_value_r);
  assign out_src2       = src2_r;
  assign out_imm        = $signed(imm_r);
  assign out_pc         = pc_r;
  assign out_occupancy  = occupancy_r;
  assign out_is_full    = is_full_r;
  assign out_removed    = removed_r;

endmodule

### rtl/core/lsqs_mem.sv
module lsqs_mem
  import lsqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int EW          = 84,
  parameter int TW          = 4
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  logic [EW-1:0]                  wr_entry,
  input  logic [TW-1:0]                  wr_tag,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output logic [EW-1:0]                  rd_entry,
  output logic [TW-1:0]                  rd_tag
);

  logic [EW-1:0] entry_mem [QUEUE_DEPTH];
  logic [TW-1:0] tag_mem   [QUEUE_DEPTH];
  logic [EW-1:0] rd_entry_r;
  logic [TW-1:0] rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
      tag_mem[wr_addr]   <= wr_tag;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_entry_r <= entry_mem[rd_addr];
    rd_tag_r   <= tag_mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;
  assign rd_tag   = rd_tag_r;

endmodule

### rtl/core/lsqs_ctrl.sv
module lsqs_ctrl
  import lsqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int TW          = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_req_type,
  input  logic [TW-1:0]                    in_cf_tag,
  output logic                             wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   wr_addr,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   rd_addr,
  input  logic [TW-1:0]                    rd_tag,
  input  logic                             res_ready,
  output res_ctl_t                         res_ctl,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   res_slot,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] res_occupancy,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] res_removed
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH = CW'(QUEUE_DEPTH);

  lsqs_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic [TW-1:0] sq_tag_r, sq_tag_nxt;
  status_t       hold_status_r, hold_status_nxt;
  logic [AW-1:0] hold_slot_r, hold_slot_nxt;

  logic [AW-1:0] head_inc, tail_inc, tail_dec;
  logic [CW-1:0] count_inc, count_dec;
  logic          imm_res;

  assign head_inc  = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec  = (tail_r == '0) ? LAST : tail_r - 1'b1;
  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  assign in_ready = (state_r == S_IDLE);
  assign wr_addr  = tail_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    removed_nxt     = removed_r;
    sq_tag_nxt      = sq_tag_r;
    hold_status_nxt = hold_status_r;
    hold_slot_nxt   = hold_slot_r;
    wr_en           = 1'b0;
    rd_addr         = head_r;
    imm_res         = 1'b0;
    res_ctl.valid   = 1'b0;
    res_ctl.status  = STAT_DONE;
    res_ctl.pop     = 1'b0;
    res_ctl.full    = (count_r == DEPTH);
    res_slot        = '0;
    res_occupancy   = count_r;
    res_removed     = '0;

    case (state_r)
      S_IDLE: begin
        // squash starts reading the tail tag right at accept
        if (in_req_type == REQ_SQUASH) begin
          rd_addr = tail_dec;
        end
        if (in_valid) begin
          case (in_req_type)
            REQ_INSERT: begin
              imm_res = 1'b1;
              if (count_r == DEPTH) begin
                res_ctl.status = STAT_FULL;
              end else begin
                wr_en         = 1'b1;
                res_slot      = count_r[AW-1:0];
                count_nxt     = count_inc;
                tail_nxt      = tail_inc;
                res_occupancy = count_inc;
                res_ctl.full  = (count_inc == DEPTH);
              end
            end
            REQ_POP: begin
              if (count_r == '0) begin
                imm_res        = 1'b1;
                res_ctl.status = STAT_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            REQ_SQUASH: begin
              if (count_r == '0) begin
                imm_res        = 1'b1;
                res_ctl.status = STAT_EMPTY;
              end else begin
                removed_nxt = '0;
                sq_tag_nxt  = in_cf_tag;
                state_nxt   = S_SQ_CMP;
              end
            end
            default: begin
              imm_res = 1'b1;
            end
          endcase
          res_ctl.valid = imm_res;
          // output stage busy: park the result
          if (imm_res && !res_ready) begin
            hold_status_nxt = res_ctl.status;
            hold_slot_nxt   = res_slot;
            state_nxt       = S_HOLD;
          end
        end
      end

      S_HOLD: begin
        res_ctl.valid  = 1'b1;
        res_ctl.status = hold_status_r;
        res_slot       = hold_slot_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_POP: begin
        // head data is in the read register; address held so it stays put
        res_ctl.valid = 1'b1;
        res_ctl.pop   = 1'b1;
        res_occupancy = count_dec;
        res_ctl.full  = 1'b0;
        if (res_ready) begin
          count_nxt = count_dec;
          head_nxt  = head_inc;
          state_nxt = S_IDLE;
        end
      end

      S_SQ_RD: begin
        rd_addr   = tail_dec;
        state_nxt = S_SQ_CMP;
      end

      S_SQ_CMP: begin
        rd_addr = tail_dec;
        if ((count_r != '0) && (rd_tag == sq_tag_r)) begin
          count_nxt   = count_dec;
          tail_nxt    = tail_dec;
          removed_nxt = removed_r + 1'b1;
          state_nxt   = S_SQ_RD;
        end else begin
          res_ctl.valid = 1'b1;
          res_removed   = removed_r;
          if (res_ready) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    removed_r     <= removed_nxt;
    sq_tag_r      <= sq_tag_nxt;
    hold_status_r <= hold_status_nxt;
    hold_slot_r   <= hold_slot_nxt;
  end

endmodule

### tb/sv/load_store_queue_with_squash_unit_tb.sv
module load_store_queue_with_squash_unit_tb
  import lsqs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = 32;
  localparam int PREGS  = 64;
  localparam int TAGS   = 16;
  localparam int PREG_W = $clog2(PREGS);
  localparam int TAG_W  = $clog2(TAGS);
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // request code the block has no use for; it must still answer with one word
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int N_RANDOM   = 1650;
  localparam int HOLD_LEN   = 400;   // receiver hold-off, in cycles
  localparam int SETTLE_CYC = 80;

  // one request word as driven on in_*
  typedef struct {
    logic [1:0]        kind;
    logic              is_store;
    logic [PREG_W-1:0] dest;
    logic [PREG_W-1:0] src1;
    logic [VAL_W-1:0]  value;
    logic              src1_rdy;
    logic [PREG_W-1:0] src2;
    logic [IMM_W-1:0]  imm;
    logic [PC_W-1:0]   pc;
    logic [TAG_W-1:0]  tag;
  } lsq_req_t;

  // one result word as seen on out_*
  typedef struct {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              is_store;
    logic [PREG_W-1:0] dest;
    logic [PREG_W-1:0] src1;
    logic [VAL_W-1:0]  value;
    logic [PREG_W-1:0] src2;
    logic [IMM_W-1:0]  imm;
    logic [PC_W-1:0]   pc;
    logic [CNT_W-1:0]  occupancy;
    logic              full;
    logic [CNT_W-1:0]  removed;
  } lsq_result_t;

  // Queue model plus the list of result words still owed by the block.
  class lsq_scoreboard;
    lsq_req_t    held[$];       // queued entries, head at index 0
    lsq_result_t due_words[$];  // expected result words, oldest first
    int          errors = 0;

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      errors++;
    endtask

    function int depth_now();
      return held.size();
    endfunction

    function logic [TAG_W-1:0] tail_tag();
      return held[held.size() - 1].tag;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // apply one accepted request to the model, queue the word it must produce
    function void note_request(lsq_req_t w);
      lsq_result_t r;
      lsq_req_t    head;
      r = '{default: '0};
      r.status = STAT_DONE;
      case (w.kind)
        REQ_INSERT: begin
          if (held.size() >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            r.slot = SLOT_W'(held.size());
            held.push_back(w);
          end
        end
        REQ_POP: begin
          if (held.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            head       = held.pop_front();
            r.is_store = head.is_store;
            r.dest     = head.dest;
            r.src1     = head.src1;
            r.value    = head.value;
            r.src2     = head.src2;
            r.imm      = head.imm;
            r.pc       = head.pc;
          end
        end
        REQ_SQUASH: begin
          if (held.size() == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            while (held.size() > 0 && held[held.size() - 1].tag == w.tag) begin
              void'(held.pop_back());
              r.removed++;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = CNT_W'(held.size());
      r.full      = (held.size() == DEPTH);
      due_words.push_back(r);
    endfunction

    task check_word(lsq_result_t got);
      lsq_result_t want;
      if (due_words.size() == 0) begin
        report("word with none expected, status", 32'(got.status), 32'hx);
        return;
      end
      want = due_words.pop_front();
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.slot !== want.slot) report("slot_index", 32'(got.slot), 32'(want.slot));
      if (got.is_store !== want.is_store)
        report("is_store", 32'(got.is_store), 32'(want.is_store));
      if (got.dest !== want.dest) report("dest", 32'(got.dest), 32'(want.dest));
      if (got.src1 !== want.src1) report("src1", 32'(got.src1), 32'(want.src1));
      if (got.value !== want.value) report("src1_value", got.value, want.value);
      if (got.src2 !== want.src2) report("src2", 32'(got.src2), 32'(want.src2));
      if (got.imm !== want.imm) report("imm", 32'(got.imm), 32'(want.imm));
      if (got.pc !== want.pc) report("pc", 32'(got.pc), 32'(want.pc));
      if (got.occupancy !== want.occupancy)
        report("occupancy", 32'(got.occupancy), 32'(want.occupancy));
      if (got.full !== want.full) report("is_full", 32'(got.full), 32'(want.full));
      if (got.removed !== want.removed)
        report("removed", 32'(got.removed), 32'(want.removed));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, DUT ports (all inputs known from time zero)
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  always #5 clk = ~clk;

  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type   = '0;
  logic                     in_is_store   = 1'b0;
  logic [PREG_W-1:0]        in_dest_phys  = '0;
  logic [PREG_W-1:0]        in_src1_phys  = '0;
  logic signed [VAL_W-1:0]  in_src1_value = '0;
  logic                     in_src1_ready = 1'b0;
  logic [PREG_W-1:0]        in_src2_phys  = '0;
  logic signed [IMM_W-1:0]  in_imm        = '0;
  logic [PC_W-1:0]          in_pc_in      = '0;
  logic [TAG_W-1:0]         in_cf_tag     = '0;

  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [1:0]               out_status;
  logic [SLOT_W-1:0]        out_slot_index;
  logic                     out_is_store;
  logic [PREG_W-1:0]        out_dest;
  logic [PREG_W-1:0]        out_src1;
  logic signed [VAL_W-1:0]  out_src1_value;
  logic [PREG_W-1:0]        out_src2;
  logic signed [IMM_W-1:0]  out_imm;
  logic [PC_W-1:0]          out_pc;
  logic [CNT_W-1:0]         out_occupancy;
  logic                     out_is_full;
  logic [CNT_W-1:0]         out_removed;

  load_store_queue_with_squash_unit #(
    .QUEUE_DEPTH(DEPTH),
    .PHYS_REGS  (PREGS),
    .TAG_COUNT  (TAGS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_is_store   (in_is_store),
    .in_dest_phys  (in_dest_phys),
    .in_src1_phys  (in_src1_phys),
    .in_src1_value (in_src1_value),
    .in_src1_ready (in_src1_ready),
    .in_src2_phys  (in_src2_phys),
    .in_imm        (in_imm),
    .in_pc_in      (in_pc_in),
    .in_cf_tag     (in_cf_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot_index(out_slot_index),
    .out_is_store  (out_is_store),
    .out_dest      (out_dest),
    .out_src1      (out_src1),
    .out_src1_value(out_src1_value),
    .out_src2      (out_src2),
    .out_imm       (out_imm),
    .out_pc        (out_pc),
    .out_occupancy (out_occupancy),
    .out_is_full   (out_is_full),
    .out_removed   (out_removed)
  );

  lsq_scoreboard sb = new();

  // shared by sender and receiver: quiet = no random idling on either side;
  // start_hold asks the receiver for one long hold-off
  bit quiet      = 1'b0;
  bit start_hold = 1'b0;

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // random payload; kind and tag as given
  function automatic lsq_req_t make_req(logic [1:0] kind, logic [TAG_W-1:0] tag);
    lsq_req_t w;
    w.kind     = kind;
    w.is_store = 1'($urandom_range(1));
    w.dest     = PREG_W'($urandom);
    w.src1     = PREG_W'($urandom);
    w.value    = VAL_W'($urandom);
    w.src1_rdy = 1'($urandom_range(1));
    w.src2     = PREG_W'($urandom);
    w.imm      = IMM_W'($urandom);
    w.pc       = PC_W'($urandom);
    w.tag      = tag;
    return w;
  endfunction

  // Called at a rising edge. Optional idle gap, then hold the word until
  // accepted; the model sees it at the accepting edge.
  task automatic send_req(lsq_req_t w);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= w.kind;
    in_is_store   <= w.is_store;
    in_dest_phys  <= w.dest;
    in_src1_phys  <= w.src1;
    in_src1_value <= w.value;
    in_src1_ready <= w.src1_rdy;
    in_src2_phys  <= w.src2;
    in_imm        <= w.imm;
    in_pc_in      <= w.pc;
    in_cf_tag     <= w.tag;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(w);
  endtask

  // ---------------------------------------------------------------------------
  // result side: check every accepted word, then pick next out_ready
  // ---------------------------------------------------------------------------
  initial begin
    lsq_result_t got;
    int          hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        got.status    = out_status;
        got.slot      = out_slot_index;
        got.is_store  = out_is_store;
        got.dest      = out_dest;
        got.src1      = out_src1;
        got.value     = out_src1_value;
        got.src2      = out_src2;
        got.imm       = out_imm;
        got.pc        = out_pc;
        got.occupancy = out_occupancy;
        got.full      = out_is_full;
        got.removed   = out_removed;
        sb.check_word(got);
      end
      if (start_hold) begin
        start_hold = 1'b0;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 6);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    lsq_req_t         w;
    logic [1:0]       kind;
    logic [TAG_W-1:0] epoch_tag;
    logic [TAG_W-1:0] tag;
    int               roll;
    int               phase;
    int               waited;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: empty-queue cases and the unused code
    send_req(make_req(REQ_POP, 4'd0));
    send_req(make_req(REQ_SQUASH, 4'd0));
    send_req(make_req(REQ_UNUSED, 4'd9));

    // --- field extremes: all-zero load, all-ones store, signed min/max
    w = make_req(REQ_INSERT, '0);
    w.is_store = 1'b0; w.dest = '0; w.src1 = '0; w.value = '0;
    w.src1_rdy = 1'b0; w.src2 = '0; w.imm = '0; w.pc = '0;
    send_req(w);
    w = make_req(REQ_INSERT, '1);
    w.is_store = 1'b1; w.dest = '1; w.src1 = '1; w.value = 32'h7fff_ffff;
    w.src1_rdy = 1'b1; w.src2 = '1; w.imm = 16'h7fff; w.pc = '1;
    send_req(w);
    w = make_req(REQ_INSERT, '1);
    w.value = 32'h8000_0000; w.imm = 16'h8000; w.pc = '0;
    send_req(w);
    w = make_req(REQ_INSERT, 4'd5);
    w.value = '1; w.imm = '1;
    send_req(w);
    send_req(make_req(REQ_UNUSED, 4'd0));

    // --- squash: tag miss (nothing removed), single, then a run of two
    send_req(make_req(REQ_SQUASH, 4'd3));
    send_req(make_req(REQ_SQUASH, 4'd5));
    send_req(make_req(REQ_SQUASH, '1));

    // --- pop the zero entry, then pop on empty
    send_req(make_req(REQ_POP, 4'd0));
    send_req(make_req(REQ_POP, 4'd0));

    // --- squash that runs the queue dry, then squash on empty
    send_req(make_req(REQ_INSERT, 4'd7));
    send_req(make_req(REQ_INSERT, 4'd7));
    send_req(make_req(REQ_SQUASH, 4'd7));
    send_req(make_req(REQ_SQUASH, 4'd7));

    // --- pops of random entries
    send_req(make_req(REQ_INSERT, 4'd2));
    send_req(make_req(REQ_INSERT, 4'd4));
    send_req(make_req(REQ_POP, 4'd0));
    send_req(make_req(REQ_POP, 4'd0));

    // --- random part. Phases of 60 words cycle through fill-heavy (reaches
    // full and refused inserts), drain-heavy (reaches empty) and balanced.
    // Inserts share an epoch tag that moves now and then, so squashes hit
    // runs of matching tail entries, like a branch flush.
    epoch_tag = TAG_W'($urandom);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 250) start_hold = 1'b1;      // receiver blocks, queue backs up
      quiet = (n >= 700 && n < 1000);       // stretch with no idling
      phase = (n / 60) % 3;
      roll  = $urandom_range(99);
      case (phase)
        0:       kind = (roll < 85) ? REQ_INSERT : (roll < 92) ? REQ_POP :
                        (roll < 98) ? REQ_SQUASH : REQ_UNUSED;
        1:       kind = (roll < 20) ? REQ_INSERT : (roll < 80) ? REQ_POP :
                        (roll < 97) ? REQ_SQUASH : REQ_UNUSED;
        default: kind = (roll < 45) ? REQ_INSERT : (roll < 78) ? REQ_POP :
                        (roll < 97) ? REQ_SQUASH : REQ_UNUSED;
      endcase
      if (kind == REQ_INSERT) begin
        if ($urandom_range(99) < 15) epoch_tag = TAG_W'($urandom);
        tag = ($urandom_range(99) < 85) ? epoch_tag : TAG_W'($urandom);
      end else if (kind == REQ_SQUASH && sb.depth_now() > 0 && $urandom_range(99) < 75) begin
        tag = sb.tail_tag();
      end else begin
        tag = TAG_W'($urandom);
      end
      send_req(make_req(kind, tag));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // wait out the owed words, then a margin for any stray extra word
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.pending() != 0) sb.report("words never delivered", sb.pending(), 0);

    if (sb.errors == 0) begin
      $display("load_store_queue_with_squash_unit: match");
    end else begin
      $display("load_store_queue_with_squash_unit: mismatch");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #10_000_000;
    $display("load_store_queue_with_squash_unit: mismatch");
    $finish;
  end

endmodule
